>>> src/wheel_rotation_observer_assert.svh
// Assertion macros for the wheel rotation observer checker.
`ifndef WHEEL_ROTATION_OBSERVER_ASSERT_SVH
`define WHEEL_ROTATION_OBSERVER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define WRO_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wheel rotation observer check failed");

// Next-cycle implication, disabled during reset.
`define WRO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wheel rotation observer check failed");

// Next-cycle implication that also holds across reset.
`define WRO_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("wheel rotation observer check failed");

`endif

>>> src/wro_pkg.sv
// ----------------------------------------------------------------------------
// Wheel rotation observer package
// Shared widths, register indexes, sequencer states and a saturation helper.
// ----------------------------------------------------------------------------
package wro_pkg;

  localparam int SPEED_FRAC_BITS = 8;
  localparam int NUM_W = 48 + SPEED_FRAC_BITS;
  localparam int DEN_W = 34;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  // Reciprocal of 100 scaled by 2^45; exact for numerators below 2^38.
  localparam logic [38:0] RECIP_100 = 39'd351843720889;
  // Smallest filter numerator whose quotient no longer fits in 31 bits.
  localparam logic [37:0] FLT_SAT_MAG = 38'd214748364800;

  localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_SPD_DIV,
    ST_FLT_MUL,
    ST_FLT_SUM,
    ST_FLT_MAC,
    ST_WUPD,
    ST_FORM,
    ST_BAL_START,
    ST_BAL_DIV,
    ST_BAL_WR,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic neg, input logic [NUM_W-1:0] mag);
    logic signed [31:0] res;
    if (!neg) begin
      res = (mag > NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(mag[31:0]);
    end else if (mag >= NUM_W'(33'h1_0000_0000 >> 1)) begin
      res = 32'sh8000_0000;
    end else begin
      res = -$signed(mag[31:0]);
    end
    return res;
  endfunction

endpackage

>>> src/wro_if.sv
// ----------------------------------------------------------------------------
// Wheel rotation observer channels
// Valid/ready interfaces for the poll, result and configuration requests.
// ----------------------------------------------------------------------------
interface wro_in_if;
  logic               valid;
  logic               ready;
  logic        [31:0] now_time;
  logic signed [31:0] encoder_count;
  logic               read_ok;
  modport source (output valid, now_time, encoder_count, read_ok, input ready);
  modport sink (input valid, now_time, encoder_count, read_ok, output ready);
endinterface

interface wro_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  polled_wheel;
  logic               polled;
  logic               all_ready;
  logic signed [31:0] rotation_speed;
  logic signed [15:0] rotation_balance;
  logic               motion_seen;
  modport source (output valid, polled_wheel, polled, all_ready, rotation_speed,
                  rotation_balance, motion_seen, input ready);
  modport sink (input valid, polled_wheel, polled, all_ready, rotation_speed,
                rotation_balance, motion_seen, output ready);
endinterface

interface wro_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [wro_pkg::CFG_IDX_W-1:0]    index;
  logic [wro_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/wheel_rotation_observer.sv
// ----------------------------------------------------------------------------
// Wheel rotation observer
// Polls four wheel encoders round-robin, filters wheel speeds and forms the
// rotational speed, left/right balance and motion flag.
// A refused poll or failed read goes from idle straight to the done state,
// which registers its result. A full sample may use the shared bit-serial
// divider twice: for the wheel speed and, once all four wheels are valid,
// for the balance. A new request is taken once the result is registered; a
// result not yet taken holds the block in its last state.
// Reset is synchronous and active low; it clears the wheel state and restores
// the register defaults.
// ----------------------------------------------------------------------------
module wheel_rotation_observer (
  input  logic      clk,
  input  logic      rst_n,
  wro_in_if.sink    in_chan,
  wro_out_if.source out_chan,
  wro_cfg_if.sink   cfg_chan
);

  localparam int NW = wro_pkg::NUM_W;
  localparam int DW = wro_pkg::DEN_W;
  localparam int F = wro_pkg::SPEED_FRAC_BITS;

  wro_pkg::state_t state_r, state_nxt;

  logic        [7:0]  poll_interval_r;
  logic        [30:0] motion_threshold_r;
  logic        [3:0]  wheel_valid_r;
  logic        [31:0] wheel_last_count_r [4];
  logic        [31:0] wheel_last_time_r [4];
  logic signed [31:0] wheel_speed_r [4];
  logic        [1:0]  next_wheel_r;
  logic        [31:0] last_poll_time_r;
  logic signed [31:0] rot_speed_r;
  logic signed [15:0] balance_r;
  logic               motion_r;

  logic        [31:0] now_r;
  logic        [31:0] count_r;
  logic               polled_r;
  logic        [1:0]  wheel_r;
  logic               upd_r;
  logic               neg_r;
  logic signed [39:0] p1_r;
  logic signed [NW+7:0] p2_r;

  logic [NW-1:0]  div_nq_r;
  logic [DW-1:0]  div_den_r;
  logic [DW-1:0]  div_rem_r;
  logic [wro_pkg::CNT_W-1:0] div_cnt_r;
  logic           div_last;
  logic [DW:0]    rem_sh;
  logic           rem_ge;
  logic [DW:0]    rem_sub;

  logic [76:0]    rec_acc_r;
  logic [1:0]     rec_step_r;
  logic [18:0]    mul_a_c;
  logic [19:0]    mul_b_c;
  logic [38:0]    mul_p_c;
  logic [76:0]    mul_add_c;
  logic [NW-1:0]  flt_q_c;

  logic               out_valid_r;
  logic        [1:0]  out_wheel_r;
  logic               out_polled_r;
  logic               out_all_r;
  logic signed [31:0] out_rot_r;
  logic signed [15:0] out_bal_r;
  logic               out_motion_r;

  logic        in_fire;
  logic        poll_ok;
  logic [31:0] dt_c;
  logic [31:0] delta_c;
  logic [31:0] dmag_c;
  logic [NW-1:0] spd_num_c;
  logic signed [NW:0] sample_c;
  logic signed [NW+8:0] acc_c;
  logic [NW+8:0] acc_mag_c;
  logic [3:0]  valid_after_c;
  logic signed [34:0] diff_c;
  logic [34:0] diff_mag_c;
  logic [32:0] left_c;
  logic [32:0] right_c;
  logic [33:0] sum_c;
  logic [32:0] bal_d_c;
  logic [32:0] rot_mag_c;
  logic [31:0] rot_abs_c;
  logic        out_free;

  assign in_chan.ready = (state_r == wro_pkg::ST_IDLE);
  assign in_fire = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_free = !out_valid_r || out_chan.ready;

  assign poll_ok = (last_poll_time_r == 32'd0) ||
                   ((in_chan.now_time - last_poll_time_r) >= {24'd0, poll_interval_r});

  assign rem_sh = {div_rem_r, div_nq_r[NW-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den_r};
  assign rem_sub = rem_sh - {1'b0, div_den_r};
  assign div_last = (div_cnt_r == wro_pkg::CNT_W'(NW - 1));

  // The filter division by 100 is a reciprocal multiply done as four
  // 19 by 20 bit partial products.
  always_comb begin
    case (rec_step_r)
      2'd0: begin
        mul_a_c = div_nq_r[18:0];
        mul_b_c = wro_pkg::RECIP_100[19:0];
      end
      2'd1: begin
        mul_a_c = div_nq_r[18:0];
        mul_b_c = {1'b0, wro_pkg::RECIP_100[38:20]};
      end
      2'd2: begin
        mul_a_c = div_nq_r[37:19];
        mul_b_c = wro_pkg::RECIP_100[19:0];
      end
      default: begin
        mul_a_c = div_nq_r[37:19];
        mul_b_c = {1'b0, wro_pkg::RECIP_100[38:20]};
      end
    endcase
    mul_p_c = 39'(mul_a_c) * 39'(mul_b_c);
    case (rec_step_r)
      2'd0: mul_add_c = {38'd0, mul_p_c};
      2'd1: mul_add_c = {38'd0, mul_p_c} << 20;
      2'd2: mul_add_c = {38'd0, mul_p_c} << 19;
      default: mul_add_c = {38'd0, mul_p_c} << 39;
    endcase
    flt_q_c = (div_nq_r >= NW'(wro_pkg::FLT_SAT_MAG)) ? NW'(32'h8000_0000)
                                                      : NW'(rec_acc_r[76:45]);
  end

  always_comb begin
    dt_c = now_r - wheel_last_time_r[wheel_r];
    delta_c = count_r - wheel_last_count_r[wheel_r];
    dmag_c = delta_c[31] ? (~delta_c + 32'd1) : delta_c;
    spd_num_c = NW'((({{(NW-32){1'b0}}, dmag_c} * NW'(1000)) << F) + NW'(dt_c >> 1));
    sample_c = neg_r ? -$signed({1'b0, div_nq_r}) : $signed({1'b0, div_nq_r});
    acc_c = $signed({{(NW-31){p1_r[39]}}, p1_r}) + $signed({p2_r[NW+7], p2_r});
    acc_mag_c = acc_c[NW+8] ? (~acc_c + 1'b1) : acc_c;
    valid_after_c = wheel_valid_r;
    valid_after_c[wheel_r] = 1'b1;
    diff_c = 35'(wheel_speed_r[0]) - 35'(wheel_speed_r[1])
           + 35'(wheel_speed_r[2]) - 35'(wheel_speed_r[3]);
    diff_mag_c = diff_c[34] ? 35'(-diff_c) : 35'(diff_c);
    left_c = 33'(wheel_speed_r[0][31] ? -34'(wheel_speed_r[0]) : 34'(wheel_speed_r[0]))
           + 33'(wheel_speed_r[2][31] ? -34'(wheel_speed_r[2]) : 34'(wheel_speed_r[2]));
    right_c = 33'(wheel_speed_r[1][31] ? -34'(wheel_speed_r[1]) : 34'(wheel_speed_r[1]))
            + 33'(wheel_speed_r[3][31] ? -34'(wheel_speed_r[3]) : 34'(wheel_speed_r[3]));
    sum_c = {1'b0, left_c} + {1'b0, right_c};
    bal_d_c = (left_c < right_c) ? (right_c - left_c) : (left_c - right_c);
    rot_mag_c = 33'((diff_mag_c + 35'd2) >> 2);
    rot_abs_c = rot_speed_r[31] ? (~rot_speed_r + 32'd1) : rot_speed_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wro_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (poll_ok && in_chan.read_ok) ? wro_pkg::ST_PREP : wro_pkg::ST_DONE;
        end
      end
      wro_pkg::ST_PREP: begin
        state_nxt = (wheel_valid_r[wheel_r] && dt_c != 32'd0) ? wro_pkg::ST_SPD_DIV
                                                              : wro_pkg::ST_WUPD;
      end
      wro_pkg::ST_SPD_DIV: if (div_last) state_nxt = wro_pkg::ST_FLT_MUL;
      wro_pkg::ST_FLT_MUL: state_nxt = wro_pkg::ST_FLT_SUM;
      wro_pkg::ST_FLT_SUM: state_nxt = wro_pkg::ST_FLT_MAC;
      wro_pkg::ST_FLT_MAC: if (rec_step_r == 2'd3) state_nxt = wro_pkg::ST_WUPD;
      wro_pkg::ST_WUPD: begin
        state_nxt = (&valid_after_c) ? wro_pkg::ST_FORM : wro_pkg::ST_DONE;
      end
      wro_pkg::ST_FORM: state_nxt = wro_pkg::ST_BAL_START;
      wro_pkg::ST_BAL_START: begin
        state_nxt = (div_den_r <= DW'(34'd1 << F)) ? wro_pkg::ST_DONE : wro_pkg::ST_BAL_DIV;
      end
      wro_pkg::ST_BAL_DIV: if (div_last) state_nxt = wro_pkg::ST_BAL_WR;
      wro_pkg::ST_BAL_WR: state_nxt = wro_pkg::ST_DONE;
      wro_pkg::ST_DONE: if (out_free) state_nxt = wro_pkg::ST_IDLE;
      default: state_nxt = wro_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wro_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_interval_r <= 8'd10;
      motion_threshold_r <= 31'd25600;
      wheel_valid_r <= 4'd0;
      for (int i = 0; i < 4; i++) begin
        wheel_last_count_r[i] <= 32'd0;
        wheel_last_time_r[i] <= 32'd0;
        wheel_speed_r[i] <= 32'sd0;
      end
      next_wheel_r <= 2'd0;
      last_poll_time_r <= 32'd0;
      rot_speed_r <= 32'sd0;
      balance_r <= 16'sd0;
      motion_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_chan.valid) begin
        if (cfg_chan.index == wro_pkg::CFG_POLL_INTERVAL) begin
          poll_interval_r <= (cfg_chan.data[7:0] == 8'd0) ? 8'd1 : cfg_chan.data[7:0];
        end else if (cfg_chan.index == wro_pkg::CFG_MOTION_THRESHOLD) begin
          motion_threshold_r <= cfg_chan.data[30:0];
        end
      end
      if (out_valid_r && out_chan.ready && state_r != wro_pkg::ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        wro_pkg::ST_IDLE: begin
          if (in_fire) begin
            now_r <= in_chan.now_time;
            count_r <= in_chan.encoder_count;
            polled_r <= poll_ok;
            wheel_r <= next_wheel_r;
            if (poll_ok) begin
              last_poll_time_r <= in_chan.now_time;
              next_wheel_r <= next_wheel_r + 2'd1;
            end
          end
        end
        wro_pkg::ST_PREP: begin
          upd_r <= wheel_valid_r[wheel_r] && (dt_c != 32'd0);
          neg_r <= delta_c[31];
          div_nq_r <= spd_num_c;
          div_den_r <= DW'(dt_c);
          div_rem_r <= '0;
          div_cnt_r <= '0;
        end
        wro_pkg::ST_SPD_DIV, wro_pkg::ST_BAL_DIV: begin
          div_rem_r <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          div_nq_r <= {div_nq_r[NW-2:0], rem_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        wro_pkg::ST_FLT_MUL: begin
          p1_r <= 40'(wheel_speed_r[wheel_r]) * 40'sd65;
          p2_r <= (NW+8)'(sample_c) * (NW+8)'(35);
        end
        wro_pkg::ST_FLT_SUM: begin
          neg_r <= acc_c[NW+8];
          div_nq_r <= NW'(acc_mag_c + (NW+9)'(50));
          rec_acc_r <= '0;
          rec_step_r <= '0;
        end
        wro_pkg::ST_FLT_MAC: begin
          rec_acc_r <= rec_acc_r + mul_add_c;
          rec_step_r <= rec_step_r + 2'd1;
        end
        wro_pkg::ST_WUPD: begin
          if (upd_r) begin
            wheel_speed_r[wheel_r] <= wro_pkg::sat32(neg_r, flt_q_c);
          end
          wheel_valid_r[wheel_r] <= 1'b1;
          wheel_last_count_r[wheel_r] <= count_r;
          wheel_last_time_r[wheel_r] <= now_r;
        end
        wro_pkg::ST_FORM: begin
          rot_speed_r <= wro_pkg::sat32(diff_c[34], NW'(rot_mag_c));
          neg_r <= left_c < right_c;
          div_nq_r <= NW'({bal_d_c, 15'd0} + 48'(sum_c >> 1));
          div_den_r <= sum_c;
          div_rem_r <= '0;
          div_cnt_r <= '0;
        end
        wro_pkg::ST_BAL_START: begin
          motion_r <= rot_abs_c >= {1'b0, motion_threshold_r};
          if (div_den_r <= DW'(34'd1 << F)) begin
            balance_r <= 16'sd0;
          end
        end
        wro_pkg::ST_BAL_WR: begin
          if (neg_r) begin
            balance_r <= (div_nq_r > NW'(32768)) ? 16'sh8000 : 16'(-$signed(div_nq_r[16:0]));
          end else begin
            balance_r <= (div_nq_r > NW'(32767)) ? 16'sh7FFF : $signed(div_nq_r[15:0]);
          end
        end
        wro_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_wheel_r <= polled_r ? wheel_r : 2'd0;
            out_polled_r <= polled_r;
            out_all_r <= &wheel_valid_r;
            out_rot_r <= rot_speed_r;
            out_bal_r <= balance_r;
            out_motion_r <= motion_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.polled_wheel = out_wheel_r;
  assign out_chan.polled = out_polled_r;
  assign out_chan.all_ready = out_all_r;
  assign out_chan.rotation_speed = out_rot_r;
  assign out_chan.rotation_balance = out_bal_r;
  assign out_chan.motion_seen = out_motion_r;

endmodule

>>> src/wro_checker.sv
// ----------------------------------------------------------------------------
// Wheel rotation observer checker
// Port-level checks on the result channel and reset behavior.
// ----------------------------------------------------------------------------
`include "wheel_rotation_observer_assert.svh"

module wro_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic        [1:0]  out_polled_wheel,
  input logic               out_polled,
  input logic               out_all_ready,
  input logic signed [31:0] out_rotation_speed,
  input logic signed [15:0] out_rotation_balance,
  input logic               out_motion_seen
);

  logic        out_stall;
  logic        out_unready;
  logic        held_zero;
  logic [52:0] out_payload;

  assign out_stall = out_valid && !out_ready;
  assign out_unready = out_valid && !out_all_ready;
  assign held_zero = (out_rotation_speed == 32'sd0) && (out_rotation_balance == 16'sd0) &&
                     !out_motion_seen;
  assign out_payload = {out_polled_wheel, out_polled, out_all_ready, out_rotation_speed,
                        out_rotation_balance, out_motion_seen};

  `WRO_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload))
  `WRO_ASSERT_NOW(a_unpolled_wheel, out_valid && !out_polled, out_polled_wheel == 2'd0)
  `WRO_ASSERT_NOW(a_not_ready_zero, out_unready, held_zero)
  `WRO_ASSERT_RST(a_reset_idle, !rst_n, in_ready && !out_valid)

endmodule

bind wheel_rotation_observer wro_port_checks u_port_checks (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_polled_wheel(out_chan.polled_wheel),
  .out_polled(out_chan.polled),
  .out_all_ready(out_chan.all_ready),
  .out_rotation_speed(out_chan.rotation_speed),
  .out_rotation_balance(out_chan.rotation_balance),
  .out_motion_seen(out_chan.motion_seen)
);

>>> tb/wro_checker.sv
// ----------------------------------------------------------------------------
// Wheel rotation observer checker
// Watches the poll, result and configuration channels. It predicts every
// result from its own model of the wheel filters, then compares the
// results field by field, in order.
// ----------------------------------------------------------------------------
module wro_checker (
  input  logic clk,
  input  logic rst_n,
  wro_in_if    in_chan,
  wro_out_if   out_chan,
  wro_cfg_if   cfg_chan,
  output int   errors,
  output int   outstanding
);

  typedef struct {
    logic [1:0]         wheel;
    logic               polled;
    logic               all_ready;
    logic signed [31:0] speed;
    logic signed [15:0] balance;
    logic               motion;
  } poll_result_t;

  poll_result_t       expected_results[$];

  logic [7:0]         poll_gap;
  logic [30:0]        motion_limit;
  logic               wheel_ok[4];
  logic [31:0]        count_seen[4];
  logic [31:0]        time_seen[4];
  logic signed [31:0] wheel_rate[4];
  logic [1:0]         wheel_due;
  logic [31:0]        poll_stamp;
  logic signed [31:0] rot_rate;
  logic signed [15:0] lr_balance;
  logic               moving;

  function automatic logic [63:0] round_quot(logic [63:0] num, logic [63:0] den);
    return (num + den / 2) / den;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [31:0] clamp32(logic neg, logic [63:0] mag);
    if (!neg) begin
      return mag > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : mag[31:0];
    end
    if (mag >= 64'h8000_0000) begin
      return 32'sh8000_0000;
    end
    return -mag[31:0];
  endfunction

  function automatic logic all_wheels_ok();
    return wheel_ok[0] && wheel_ok[1] && wheel_ok[2] && wheel_ok[3];
  endfunction

  task automatic form_rotation();
    longint      fl, fr, rl, rr, diff;
    logic [63:0] left, right, total, d, q;
    fl = wheel_rate[0];
    fr = wheel_rate[1];
    rl = wheel_rate[2];
    rr = wheel_rate[3];
    diff = fl - fr + rl - rr;
    left = magnitude(fl) + magnitude(rl);
    right = magnitude(fr) + magnitude(rr);
    total = left + right;
    rot_rate = clamp32(diff < 0, round_quot(magnitude(diff), 64'd4));
    if (total <= (64'd1 << wro_pkg::SPEED_FRAC_BITS)) begin
      lr_balance = '0;
    end else if (left < right) begin
      d = right - left;
      q = round_quot(d << 15, total);
      lr_balance = q > 64'd32768 ? 16'sh8000 : 16'(-q);
    end else begin
      d = left - right;
      q = round_quot(d << 15, total);
      lr_balance = q > 64'd32767 ? 16'sh7FFF : q[15:0];
    end
    moving = magnitude(longint'(rot_rate)) >= {33'b0, motion_limit};
  endtask

  task automatic predict_poll(logic [31:0] now, logic [31:0] count, logic ok);
    poll_result_t r;
    logic [1:0]   w;
    logic [31:0]  dt, d;
    logic [63:0]  dmag, smag;
    longint       sample, acc;
    r.polled = 1'b0;
    r.wheel = '0;
    if (poll_stamp == 0 || (now - poll_stamp) >= {24'b0, poll_gap}) begin
      r.polled = 1'b1;
      poll_stamp = now;
      w = wheel_due;
      r.wheel = w;
      wheel_due = wheel_due + 2'd1;
      if (ok) begin
        if (wheel_ok[w]) begin
          dt = now - time_seen[w];
          if (dt != 0) begin
            d = count - count_seen[w];
            dmag = d[31] ? {32'b0, -d} : {32'b0, d};
            smag = round_quot((dmag * 64'd1000) << wro_pkg::SPEED_FRAC_BITS, {32'b0, dt});
            sample = d[31] ? -longint'(smag) : longint'(smag);
            acc = longint'(wheel_rate[w]) * 65 + sample * 35;
            wheel_rate[w] = clamp32(acc < 0, round_quot(magnitude(acc), 64'd100));
          end
        end
        wheel_ok[w] = 1'b1;
        count_seen[w] = count;
        time_seen[w] = now;
        if (all_wheels_ok()) begin
          form_rotation();
        end
      end
    end
    r.all_ready = all_wheels_ok();
    r.speed = rot_rate;
    r.balance = lr_balance;
    r.motion = moving;
    expected_results.push_back(r);
  endtask

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    poll_result_t r;
    if (!rst_n) begin
      errors = 0;
      outstanding = 0;
      expected_results.delete();
      poll_gap = 8'd10;
      motion_limit = 31'd25600;
      for (int i = 0; i < 4; i++) begin
        wheel_ok[i] = 1'b0;
        count_seen[i] = '0;
        time_seen[i] = '0;
        wheel_rate[i] = '0;
      end
      wheel_due = '0;
      poll_stamp = '0;
      rot_rate = '0;
      lr_balance = '0;
      moving = 1'b0;
    end else begin
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == wro_pkg::CFG_POLL_INTERVAL) begin
          poll_gap = cfg_chan.data[7:0] == 0 ? 8'd1 : cfg_chan.data[7:0];
        end else if (cfg_chan.index == wro_pkg::CFG_MOTION_THRESHOLD) begin
          motion_limit = cfg_chan.data[30:0];
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        predict_poll(in_chan.now_time, in_chan.encoder_count, in_chan.read_ok);
      end
      if (out_chan.valid && out_chan.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending", $time);
          errors++;
        end else begin
          r = expected_results.pop_front();
          report("polled_wheel", r.wheel, out_chan.polled_wheel);
          report("polled", r.polled, out_chan.polled);
          report("all_ready", r.all_ready, out_chan.all_ready);
          report("rotation_speed", 32'(r.speed), 32'(out_chan.rotation_speed));
          report("rotation_balance", 16'(r.balance), 16'(out_chan.rotation_balance));
          report("motion_seen", r.motion, out_chan.motion_seen);
        end
      end
      outstanding = expected_results.size();
    end
  end

endmodule

>>> tb/wheel_rotation_observer_tb.sv
// ----------------------------------------------------------------------------
// Wheel rotation observer testbench
// Drives directed and random poll requests and register writes under
// varying back-pressure; a checker beside the block judges every result.
// ----------------------------------------------------------------------------
module wheel_rotation_observer_tb;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;
  int   errors;
  int   outstanding;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;

  logic [31:0] now_ms;
  logic [31:0] wheel_count[4];
  int          poll_slot;

  wro_in_if  in_chan ();
  wro_out_if out_chan ();
  wro_cfg_if cfg_chan ();

  wheel_rotation_observer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  wro_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_chan    (cfg_chan),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_poll(logic [31:0] now, logic [31:0] count, logic ok);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.now_time <= now;
    in_chan.encoder_count <= count;
    in_chan.read_ok <= ok;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [wro_pkg::CFG_IDX_W-1:0] idx,
                           logic [wro_pkg::CFG_DATA_W-1:0] value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_polls(int n, int gap, int idle_pct, int stall_pct, logic hold_off);
    int k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (hold_off && i == n / 2) begin
        drain();
      end
      case ($urandom_range(39))
        0:       now_ms = $urandom;
        1, 2, 3: now_ms = now_ms + $urandom_range(0, gap);
        default: now_ms = now_ms + gap + $urandom_range(0, 40);
      endcase
      k = poll_slot % 4;
      poll_slot++;
      if ($urandom_range(19) == 0) begin
        wheel_count[k] = $urandom;
      end else begin
        wheel_count[k] = wheel_count[k] + $urandom_range(0, 40000) - 20000;
      end
      send_poll(now_ms, wheel_count[k], $urandom_range(11) != 0);
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.now_time <= '0;
    in_chan.encoder_count <= '0;
    in_chan.read_ok <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= '0;
    cfg_chan.data <= '0;
    cycles <= 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    now_ms = 32'd1000;
    poll_slot = 0;
    for (int i = 0; i < 4; i++) wheel_count[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: startup polls at time zero, a refused request, a failed
    // read, and count steps at both extremes.
    send_poll(32'd0, 32'd0, 1'b1);
    send_poll(32'd0, 32'h7FFF_FFFF, 1'b1);
    send_poll(32'd3, 32'h8000_0000, 1'b1);
    send_poll(32'd5, 32'd77, 1'b1);
    send_poll(32'd13, 32'd100, 1'b0);
    send_poll(32'd23, 32'hFFFF_FFFB, 1'b1);
    send_poll(32'd33, 32'hFFFF_FFFF, 1'b1);
    send_poll(32'd34, 32'd9, 1'b1);
    send_poll(32'd43, 32'd1000, 1'b1);
    send_poll(32'd53, 32'd12345, 1'b1);
    send_poll(32'd54, 32'h8000_3039, 1'b1);
    drain();

    // A zero interval becomes one; time wraps back for a zero elapsed time.
    write_reg(wro_pkg::CFG_POLL_INTERVAL, 32'd0);
    write_reg(wro_pkg::CFG_MOTION_THRESHOLD, 32'd0);
    send_poll(32'd100, 32'd500, 1'b1);
    send_poll(32'h4000_0064, 32'd600, 1'b1);
    send_poll(32'h8000_0064, 32'd700, 1'b1);
    send_poll(32'hC000_0064, 32'd800, 1'b1);
    send_poll(32'd100, 32'd900, 1'b1);
    send_poll(32'd0, 32'd950, 1'b1);
    send_poll(32'd0, 32'h7FFF_FFFF, 1'b1);
    send_poll(32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_poll(32'd1, 32'd0, 1'b1);
    drain();

    write_reg(wro_pkg::CFG_POLL_INTERVAL, 32'd255);
    write_reg(wro_pkg::CFG_MOTION_THRESHOLD, 32'h7FFF_FFFF);
    random_polls(650, 255, 14, 86, 1'b1);

    write_reg(wro_pkg::CFG_POLL_INTERVAL, 32'd10);
    write_reg(wro_pkg::CFG_MOTION_THRESHOLD, 32'd3000);
    random_polls(650, 10, 86, 14, 1'b0);

    write_reg(wro_pkg::CFG_POLL_INTERVAL, 32'd2);
    write_reg(wro_pkg::CFG_MOTION_THRESHOLD, 32'd200000);
    random_polls(700, 2, 0, 0, 1'b0);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> wheel_rotation_observer.f
+incdir+src
src/wro_pkg.sv
src/wro_if.sv
src/wheel_rotation_observer.sv
src/wro_checker.sv
tb/wro_checker.sv
tb/wheel_rotation_observer_tb.sv
